>>> design/sample_stats_confidence_core_assert.svh
// Assertion macros used by the checker file scc_checker.sv.
`ifndef SAMPLE_STATS_CONFIDENCE_CORE_ASSERT_SVH
`define SAMPLE_STATS_CONFIDENCE_CORE_ASSERT_SVH

// same-cycle implication
`define SCC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scc assertion failed");

// next-cycle implication
`define SCC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scc assertion failed");

`endif

>>> design/scc_pkg.sv
package scc_pkg;

   localparam int SAMPLE_W = 13;
   localparam int SIZE_W   = 11;
   localparam int MEAN_W   = 21;
   localparam int FRAC_W   = 17;
   localparam int VAR_W    = 32;
   localparam int PROD_W   = SAMPLE_W + SIZE_W;
   localparam int ACC_W    = 64;
   localparam int NUM_W    = 80;
   localparam int DEN_W    = 34;
   localparam int SQ_W     = 44;
   localparam int ROOT_W   = SQ_W / 2;
   localparam int V16_W    = 41;
   localparam int KNUM_W   = 12;
   localparam int KDEN_W   = 10;
   localparam int HNUM_W   = KNUM_W + V16_W;
   localparam int NN_W     = 2 * SIZE_W;
   localparam int N3_W     = 3 * SIZE_W;
   localparam int D5_W     = KDEN_W + SIZE_W;

   localparam logic [MEAN_W-1:0] MEAN_CAP = 21'd1048576;
   localparam logic [FRAC_W-1:0] FRAC_CAP = 17'd65536;
   localparam logic [V16_W-1:0]  V16_CAP  = 41'h100_0000_0000;
   localparam logic [KNUM_W-1:0] K_NUM    = 12'd2401;  // 1.96^2 = 2401/625
   localparam logic [KDEN_W-1:0] K_DEN    = 10'd625;

   typedef enum logic [1:0] {
      DIV_MEAN = 2'd0,
      DIV_ZERO = 2'd1,
      DIV_VAR  = 2'd2,
      DIV_HALF = 2'd3
   } div_sel_type;

   typedef enum logic {
      SQRT_STD  = 1'b0,
      SQRT_HALF = 1'b1
   } sqrt_sel_type;

   typedef struct packed {
      logic         store;
      logic         pass_init;
      logic         rd;
      logic         diff;
      logic         sq;
      logic         acc;
      logic         n_mul;
      logic         n_cube;
      logic         num_mul;
      logic         div_start;
      div_sel_type  div_sel;
      logic         sqrt_start;
      sqrt_sel_type sqrt_sel;
      logic         finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic last_idx;
      logic div_busy;
      logic div_done;
      logic sqrt_busy;
      logic sqrt_done;
   } ctrl_status_type;

endpackage

>>> design/scc_interfaces.sv
interface scc_req_if import scc_pkg::*;;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] mismatch_min;
   logic                solved;
   logic                last;

   modport source (output valid, mismatch_min, solved, last, input ready);
   modport sink (input valid, mismatch_min, solved, last, output ready);
endinterface

interface scc_rsp_if import scc_pkg::*;;
   logic              valid;
   logic              ready;
   logic [MEAN_W-1:0] mean_q;
   logic [FRAC_W-1:0] zero_fraction;
   logic [VAR_W-1:0]  variance;
   logic [MEAN_W-1:0] std_dev;
   logic [MEAN_W-1:0] half_width;
   logic              overflowed;

   modport source (output valid, mean_q, zero_fraction, variance, std_dev, half_width,
                   overflowed, input ready);
   modport sink (input valid, mean_q, zero_fraction, variance, std_dev, half_width,
                 overflowed, output ready);
endinterface

interface scc_csr_if import scc_pkg::*;;
   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] sample_size;

   modport source (output valid, sample_size, input ready);
   modport sink (input valid, sample_size, output ready);
endinterface

>>> design/scc_div.sv
module scc_div import scc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);
   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   // restoring division, one quotient bit per cycle; dividend shifts out as quotient shifts in
   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

>>> design/scc_sqrt.sv
module scc_sqrt import scc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SQ_W-1:0]   radicand,
   output logic              busy,
   output logic              done,
   output logic [ROOT_W-1:0] root
);
   localparam int CNT_W = $clog2(ROOT_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SQ_W-1:0]  rem_ff, rem_in;
   logic [SQ_W-1:0]  root_ff, root_in;
   logic [SQ_W-1:0]  bit_ff, bit_in;
   logic [SQ_W-1:0]  trial;
   logic             ge;

   // digit-by-digit root, two radicand bits per cycle
   assign trial = root_ff + bit_ff;
   assign ge    = rem_ff >= trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = radicand;
         root_in = '0;
         bit_in  = SQ_W'(1) << (SQ_W - 2);
      end else if (busy_ff) begin
         rem_in  = ge ? rem_ff - trial : rem_ff;
         root_in = ge ? (root_ff >> 1) + bit_ff : root_ff >> 1;
         bit_in  = bit_ff >> 2;
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign root = root_ff[ROOT_W-1:0];
endmodule

>>> design/scc_ctrl.sv
module scc_ctrl import scc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_last,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output ctrl_cmd_type    cmd,
   input  ctrl_status_type st
);
   typedef enum logic [14:0] {
      ST_IDLE      = 15'h0001,
      ST_P_READ    = 15'h0002,
      ST_P_DIFF    = 15'h0004,
      ST_P_SQ      = 15'h0008,
      ST_P_ACC     = 15'h0010,
      ST_N_SQ      = 15'h0020,
      ST_N_CUBE    = 15'h0040,
      ST_DIV_MEAN  = 15'h0080,
      ST_DIV_ZERO  = 15'h0100,
      ST_DIV_VAR   = 15'h0200,
      ST_MUL_NUM   = 15'h0400,
      ST_DIV_HALF  = 15'h0800,
      ST_SQRT_STD  = 15'h1000,
      ST_SQRT_HALF = 15'h2000,
      ST_FINISH    = 15'h4000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           req_hs;
   logic           div_go;
   logic           sqrt_go;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_hs    = req_valid && req_ready;
   assign div_go    = !st.div_busy && !st.div_done;
   assign sqrt_go   = !st.sqrt_busy && !st.sqrt_done;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_hs) begin
               cmd.store = 1'b1;
               if (req_last) begin
                  cmd.pass_init = 1'b1;
                  state_in      = ST_P_READ;
               end
            end
         end
         ST_P_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_P_DIFF;
         end
         ST_P_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_P_SQ;
         end
         ST_P_SQ: begin
            cmd.sq   = 1'b1;
            state_in = ST_P_ACC;
         end
         ST_P_ACC: begin
            cmd.acc  = 1'b1;
            state_in = st.last_idx ? ST_N_SQ : ST_P_READ;
         end
         ST_N_SQ: begin
            cmd.n_mul = 1'b1;
            state_in  = ST_N_CUBE;
         end
         ST_N_CUBE: begin
            cmd.n_cube = 1'b1;
            state_in   = ST_DIV_MEAN;
         end
         ST_DIV_MEAN: begin
            cmd.div_sel   = DIV_MEAN;
            cmd.div_start = div_go;
            if (st.div_done) state_in = ST_DIV_ZERO;
         end
         ST_DIV_ZERO: begin
            cmd.div_sel   = DIV_ZERO;
            cmd.div_start = div_go;
            if (st.div_done) state_in = ST_DIV_VAR;
         end
         ST_DIV_VAR: begin
            cmd.div_sel   = DIV_VAR;
            cmd.div_start = div_go;
            if (st.div_done) state_in = ST_MUL_NUM;
         end
         ST_MUL_NUM: begin
            cmd.num_mul = 1'b1;
            state_in    = ST_DIV_HALF;
         end
         ST_DIV_HALF: begin
            cmd.div_sel   = DIV_HALF;
            cmd.div_start = div_go;
            if (st.div_done) state_in = ST_SQRT_STD;
         end
         ST_SQRT_STD: begin
            cmd.sqrt_sel   = SQRT_STD;
            cmd.sqrt_start = sqrt_go;
            if (st.sqrt_done) state_in = ST_SQRT_HALF;
         end
         ST_SQRT_HALF: begin
            cmd.sqrt_sel   = SQRT_HALF;
            cmd.sqrt_start = sqrt_go;
            if (st.sqrt_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // wait until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.finish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

>>> design/scc_datapath.sv
module scc_datapath import scc_pkg::*; #(
   parameter int MAX_SAMPLES = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output ctrl_status_type     st,
   input  logic                csr_we,
   input  logic [SIZE_W-1:0]   csr_data,
   input  logic [SAMPLE_W-1:0] mismatch_min,
   input  logic                solved,
   output logic [MEAN_W-1:0]   mean_q,
   output logic [FRAC_W-1:0]   zero_fraction,
   output logic [VAR_W-1:0]    variance,
   output logic [MEAN_W-1:0]   std_dev,
   output logic [MEAN_W-1:0]   half_width,
   output logic                overflowed
);
   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int ADDR_W = $clog2(MAX_SAMPLES);
   localparam int SUM_W  = SAMPLE_W + CNT_W;
   localparam int D_W    = (SUM_W > PROD_W) ? SUM_W : PROD_W;
   localparam int SQR_W  = 2 * D_W;

   logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];

   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    zero_ff, zero_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic                drop_ff, drop_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [SAMPLE_W-1:0] rd_ff;
   logic [D_W-1:0]      diff_ff;
   logic [SQR_W-1:0]    sq_ff;
   logic [ACC_W-1:0]    t_ff, t_in;
   logic [NN_W-1:0]     nn_ff;
   logic [N3_W-1:0]     n3_ff;
   logic [D5_W-1:0]     d5_ff;
   logic [HNUM_W-1:0]   num_ff;
   logic [MEAN_W-1:0]   mean_ff;
   logic [FRAC_W-1:0]   frac_ff;
   logic [VAR_W-1:0]    var_ff;
   logic [V16_W-1:0]    v16_ff;
   logic [SQ_W-1:0]     hq_ff;
   logic [MEAN_W-1:0]   std_ff;
   logic [MEAN_W-1:0]   hw_ff;
   logic [MEAN_W-1:0]   out_mean_ff;
   logic [FRAC_W-1:0]   out_frac_ff;
   logic [VAR_W-1:0]    out_var_ff;
   logic [MEAN_W-1:0]   out_std_ff;
   logic [MEAN_W-1:0]   out_hw_ff;
   logic                out_ovf_ff;

   logic [SAMPLE_W-1:0] x;
   logic                room;
   logic [SIZE_W-1:0]   n_eff;
   logic [PROD_W-1:0]   a;
   logic [D_W-1:0]      a_ext;
   logic [D_W-1:0]      s_ext;
   logic [ACC_W:0]      t_sum;
   logic [NUM_W-1:0]    div_num;
   logic [DEN_W-1:0]    div_den;
   logic [NUM_W-1:0]    q;
   logic                div_busy, div_done;
   logic [SQ_W-1:0]     sq_arg;
   logic [ROOT_W-1:0]   root;
   logic                sqrt_busy, sqrt_done;
   logic [MEAN_W-1:0]   root_sat;

   assign x     = solved ? '0 : mismatch_min;
   assign room  = count_ff < CNT_W'(MAX_SAMPLES);
   assign n_eff = (size_ff == '0) ? SIZE_W'(1) : size_ff;

   // second pass: |N*x - sum|^2 accumulated with saturation
   assign a     = n_eff * rd_ff;
   assign a_ext = D_W'(a);
   assign s_ext = D_W'(sum_ff);
   assign t_sum = {1'b0, t_ff} + (ACC_W + 1)'(sq_ff);

   always_comb begin
      size_in  = csr_we ? csr_data : size_ff;
      count_in = count_ff;
      zero_in  = zero_ff;
      sum_in   = sum_ff;
      drop_in  = drop_ff;
      if (cmd.store) begin
         if (room) begin
            count_in = count_ff + CNT_W'(1);
            sum_in   = sum_ff + SUM_W'(x);
            if (x == '0) zero_in = zero_ff + CNT_W'(1);
         end else begin
            drop_in = 1'b1;
         end
      end
      if (cmd.finish) begin
         count_in = '0;
         zero_in  = '0;
         sum_in   = '0;
         drop_in  = 1'b0;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      t_in   = t_ff;
      if (cmd.pass_init) begin
         idx_in = '0;
         t_in   = '0;
      end else if (cmd.acc) begin
         idx_in = idx_ff + CNT_W'(1);
         t_in   = t_sum[ACC_W] ? '1 : t_sum[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= SIZE_W'(1);
         count_ff <= '0;
         zero_ff  <= '0;
         sum_ff   <= '0;
         drop_ff  <= 1'b0;
      end else begin
         size_ff  <= size_in;
         count_ff <= count_in;
         zero_ff  <= zero_in;
         sum_ff   <= sum_in;
         drop_ff  <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store && room) mem[count_ff[ADDR_W-1:0]] <= x;
      if (cmd.rd) rd_ff <= mem[idx_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      t_ff   <= t_in;
      if (cmd.diff) diff_ff <= (a_ext >= s_ext) ? a_ext - s_ext : s_ext - a_ext;
      if (cmd.sq) sq_ff <= diff_ff * diff_ff;
      if (cmd.n_mul) begin
         nn_ff <= n_eff * n_eff;
         d5_ff <= K_DEN * n_eff;
      end
      if (cmd.n_cube) n3_ff <= nn_ff * n_eff;
      if (cmd.num_mul) num_ff <= K_NUM * v16_ff;
   end

   always_comb begin
      case (cmd.div_sel)
         DIV_MEAN: begin
            div_num = NUM_W'({sum_ff, 8'd0});
            div_den = DEN_W'(n_eff);
         end
         DIV_ZERO: begin
            div_num = NUM_W'({zero_ff, 16'd0});
            div_den = DEN_W'(n_eff);
         end
         DIV_VAR: begin
            div_num = {t_ff, 16'd0};
            div_den = DEN_W'(n3_ff);
         end
         DIV_HALF: begin
            div_num = NUM_W'(num_ff);
            div_den = DEN_W'(d5_ff);
         end
         default: begin
            div_num = '0;
            div_den = DEN_W'(1);
         end
      endcase
   end

   scc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (q)
   );

   always_ff @(posedge clock) begin
      if (div_done) begin
         case (cmd.div_sel)
            DIV_MEAN: mean_ff <= (q > NUM_W'(MEAN_CAP)) ? MEAN_CAP : q[MEAN_W-1:0];
            DIV_ZERO: frac_ff <= (q > NUM_W'(FRAC_CAP)) ? FRAC_CAP : q[FRAC_W-1:0];
            DIV_VAR: begin
               if (q >= NUM_W'(V16_CAP)) begin
                  var_ff <= '1;
                  v16_ff <= V16_CAP;
               end else begin
                  var_ff <= q[VAR_W+7:8];
                  v16_ff <= q[V16_W-1:0];
               end
            end
            DIV_HALF: hq_ff <= q[SQ_W-1:0];
            default: hq_ff <= hq_ff;
         endcase
      end
   end

   assign sq_arg = (cmd.sqrt_sel == SQRT_HALF) ? hq_ff : SQ_W'(v16_ff);

   scc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (sq_arg),
      .busy     (sqrt_busy),
      .done     (sqrt_done),
      .root     (root)
   );

   assign root_sat = (root > ROOT_W'(MEAN_CAP)) ? MEAN_CAP : root[MEAN_W-1:0];

   always_ff @(posedge clock) begin
      if (sqrt_done) begin
         if (cmd.sqrt_sel == SQRT_HALF) hw_ff <= root_sat;
         else std_ff <= root_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_mean_ff <= mean_ff;
         out_frac_ff <= frac_ff;
         out_var_ff  <= var_ff;
         out_std_ff  <= std_ff;
         out_hw_ff   <= hw_ff;
         out_ovf_ff  <= drop_ff;
      end
   end

   assign st.last_idx  = (idx_ff + CNT_W'(1)) == count_ff;
   assign st.div_busy  = div_busy;
   assign st.div_done  = div_done;
   assign st.sqrt_busy = sqrt_busy;
   assign st.sqrt_done = sqrt_done;

   assign mean_q        = out_mean_ff;
   assign zero_fraction = out_frac_ff;
   assign variance      = out_var_ff;
   assign std_dev       = out_std_ff;
   assign half_width    = out_hw_ff;
   assign overflowed    = out_ovf_ff;
endmodule

>>> design/sample_stats_confidence_core.sv
// Transactions without last: one accepted per cycle while no set is being finished.
// Transaction with last: a variance pass (read, difference, square and accumulate for each
// stored sample), four divisions on the 1-bit-per-cycle divider and two square roots.
// The result waits in an output register; new samples are taken while it waits.
// Reset (synchronous, active high) clears the counters and sets sample_size to 1; the sample
// memory needs no clearing.
module sample_stats_confidence_core import scc_pkg::*; #(
   parameter int MAX_SAMPLES = 1024
) (
   input logic       clock,
   input logic       reset,
   scc_req_if.sink   req_bus,
   scc_rsp_if.source rsp_bus,
   scc_csr_if.sink   csr_bus
);
   ctrl_cmd_type    cmd;
   ctrl_status_type st;

   assign csr_bus.ready = 1'b1;

   scc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_last  (req_bus.last),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .st        (st)
   );

   scc_datapath #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .st            (st),
      .csr_we        (csr_bus.valid),
      .csr_data      (csr_bus.sample_size),
      .mismatch_min  (req_bus.mismatch_min),
      .solved        (req_bus.solved),
      .mean_q        (rsp_bus.mean_q),
      .zero_fraction (rsp_bus.zero_fraction),
      .variance      (rsp_bus.variance),
      .std_dev       (rsp_bus.std_dev),
      .half_width    (rsp_bus.half_width),
      .overflowed    (rsp_bus.overflowed)
   );
endmodule

>>> design/scc_checker.sv
`include "sample_stats_confidence_core_assert.svh"

module scc_checker import scc_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_last,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [MEAN_W-1:0] rsp_mean_q,
   input logic [FRAC_W-1:0] rsp_zero_fraction,
   input logic [MEAN_W-1:0] rsp_std_dev,
   input logic [MEAN_W-1:0] rsp_half_width
);
   `SCC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // a sample that does not close a set never produces a result on its own
   `SCC_ASSERT_NXT(a_no_spurious_rsp, clock, reset, req_valid && req_ready && !req_last && !rsp_valid, !rsp_valid)

   `SCC_ASSERT_IMP(a_frac_cap, clock, reset, rsp_valid, rsp_zero_fraction <= FRAC_CAP)

   `SCC_ASSERT_IMP(a_root_cap, clock, reset, rsp_valid, rsp_mean_q <= MEAN_CAP && rsp_std_dev <= MEAN_CAP && rsp_half_width <= MEAN_CAP)
endmodule

bind sample_stats_confidence_core scc_checker u_scc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .req_last          (req_bus.last),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_mean_q        (rsp_bus.mean_q),
   .rsp_zero_fraction (rsp_bus.zero_fraction),
   .rsp_std_dev       (rsp_bus.std_dev),
   .rsp_half_width    (rsp_bus.half_width)
);

>>> dv/scc_stats_checker.sv
`timescale 1ns / 100ps
module scc_stats_checker import scc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   scc_req_if          req_bus,
   scc_rsp_if          rsp_bus,
   scc_csr_if          csr_bus,
   output int unsigned fail_count,
   output int unsigned pending,
   output int unsigned samples_seen,
   output int unsigned sets_checked,
   output int unsigned overflow_sets
);

   typedef struct packed {
      logic [MEAN_W-1:0] mean_q;
      logic [FRAC_W-1:0] zero_fraction;
      logic [VAR_W-1:0]  variance;
      logic [MEAN_W-1:0] std_dev;
      logic [MEAN_W-1:0] half_width;
      logic              overflowed;
   } set_stats_type;

   localparam int unsigned STORE_DEPTH = 1024;

   logic [SAMPLE_W-1:0] sample_mem [STORE_DEPTH];
   int unsigned         set_count;
   int unsigned         zero_total;
   longint unsigned     set_sum;
   logic                dropped;
   logic [SIZE_W-1:0]   size_reg;
   set_stats_type       stats_q [$];

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // floor(t * 2^sh / d), clamped to cap
   function automatic longint unsigned fixed_div(longint unsigned t, longint unsigned d,
                                                 int sh, longint unsigned cap);
      longint unsigned q, r, v;
      q = t / d;
      r = t % d;
      if (q > (cap >> sh)) return cap;
      v = (q << sh) + ((r << sh) / d);
      return (v > cap) ? cap : v;
   endfunction

   function automatic set_stats_type finish_set();
      set_stats_type   st;
      longint unsigned n, a, d, sq, t, v16, root;
      n = (size_reg == 0) ? 1 : size_reg;
      t = 0;
      for (int unsigned i = 0; i < set_count; i++) begin
         a  = n * sample_mem[i];
         d  = (a >= set_sum) ? a - set_sum : set_sum - a;
         sq = d * d;
         t  = (t > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF : t + sq;
      end
      st.mean_q        = MEAN_W'(fixed_div(set_sum, n, 8, MEAN_CAP));
      st.zero_fraction = FRAC_W'(fixed_div(zero_total, n, 16, FRAC_CAP));
      st.variance      = VAR_W'(fixed_div(t, n * n * n, 8, 64'hFFFF_FFFF));
      v16              = fixed_div(t, n * n * n, 16, V16_CAP);
      root             = int_sqrt(v16);
      st.std_dev       = (root > MEAN_CAP) ? MEAN_CAP : MEAN_W'(root);
      root             = int_sqrt((2401 * v16) / (625 * n));
      st.half_width    = (root > MEAN_CAP) ? MEAN_CAP : MEAN_W'(root);
      st.overflowed    = dropped;
      return st;
   endfunction

   always @(posedge clock) begin
      set_stats_type       got, want;
      logic [SAMPLE_W-1:0] x;
      if (reset) begin
         set_count  <= 0;
         zero_total <= 0;
         set_sum    <= 0;
         dropped    <= 1'b0;
         size_reg   <= 11'd1;
         fail_count <= 0;
         samples_seen <= 0;
         sets_checked <= 0;
         overflow_sets <= 0;
         stats_q.delete();
         pending <= 0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) size_reg = csr_bus.sample_size;
         if (req_bus.valid && req_bus.ready) begin
            samples_seen <= samples_seen + 1;
            x = req_bus.solved ? '0 : req_bus.mismatch_min;
            if (set_count < STORE_DEPTH) begin
               sample_mem[set_count] = x;
               set_count = set_count + 1;
               set_sum   = set_sum + x;
               if (x == 0) zero_total = zero_total + 1;
            end else begin
               dropped = 1'b1;
            end
            if (req_bus.last) begin
               stats_q.insert(stats_q.size(), finish_set());
               if (dropped) overflow_sets <= overflow_sets + 1;
               set_count  = 0;
               zero_total = 0;
               set_sum    = 0;
               dropped    = 1'b0;
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.mean_q, rsp_bus.zero_fraction, rsp_bus.variance,
                    rsp_bus.std_dev, rsp_bus.half_width, rsp_bus.overflowed};
            if (stats_q.size() == 0) begin
               $error("unexpected result transaction");
               fail_count = fail_count + 1;
            end else begin
               want = stats_q.pop_front();
               sets_checked <= sets_checked + 1;
               if (got.mean_q !== want.mean_q) begin
                  $error("mean_q exp %0d got %0d", want.mean_q, got.mean_q);
                  fail_count = fail_count + 1;
               end
               if (got.zero_fraction !== want.zero_fraction) begin
                  $error("zero_fraction exp %0d got %0d", want.zero_fraction,
                         got.zero_fraction);
                  fail_count = fail_count + 1;
               end
               if (got.variance !== want.variance) begin
                  $error("variance exp %0d got %0d", want.variance, got.variance);
                  fail_count = fail_count + 1;
               end
               if (got.std_dev !== want.std_dev) begin
                  $error("std_dev exp %0d got %0d", want.std_dev, got.std_dev);
                  fail_count = fail_count + 1;
               end
               if (got.half_width !== want.half_width) begin
                  $error("half_width exp %0d got %0d", want.half_width, got.half_width);
                  fail_count = fail_count + 1;
               end
               if (got.overflowed !== want.overflowed) begin
                  $error("overflowed exp %0d got %0d", want.overflowed, got.overflowed);
                  fail_count = fail_count + 1;
               end
            end
         end
         pending <= stats_q.size();
      end
   end

endmodule

>>> dv/tb_sample_stats_confidence_core.sv
`timescale 1ns / 100ps
module tb_sample_stats_confidence_core;
   import scc_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int unsigned idle_pct  = 0;
   int unsigned stall_pct = 0;
   int unsigned cycles    = 0;
   int unsigned fail_count, pending, samples_seen, sets_checked, overflow_sets;
   int unsigned ph_idle  [4] = '{0, 66, 0, 17};
   int unsigned ph_stall [4] = '{0, 0, 66, 17};
   logic [SIZE_W-1:0] ph_size [4] = '{11'd1, 11'd2047, 11'd0, 11'd1024};

   scc_req_if req_bus();
   scc_rsp_if rsp_bus();
   scc_csr_if csr_bus();

   sample_stats_confidence_core u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   scc_stats_checker u_chk (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .csr_bus       (csr_bus),
      .fail_count    (fail_count),
      .pending       (pending),
      .samples_seen  (samples_seen),
      .sets_checked  (sets_checked),
      .overflow_sets (overflow_sets)
   );

   always #6 clock = ~clock;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.mismatch_min = '0;
      req_bus.solved = 1'b0;
      req_bus.last = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.sample_size = '0;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("sample_stats_confidence_core: mismatch");
         $finish;
      end
   end

   task automatic push_sample(input logic [SAMPLE_W-1:0] mm, input logic sv, input logic lst);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.mismatch_min <= mm;
      req_bus.solved       <= sv;
      req_bus.last         <= lst;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // drain outstanding results, then let the block settle before a register write
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_size(input logic [SIZE_W-1:0] v);
      drain();
      csr_bus.valid       <= 1'b1;
      csr_bus.sample_size <= v;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_value();
      case ($urandom_range(5))
         0: return '0;
         1: return 13'h1FFF;
         2: return 13'd4096;
         3: return SAMPLE_W'($urandom_range(15));
         default: return SAMPLE_W'($urandom_range(8191));
      endcase
   endfunction

   task automatic run_set(input int unsigned len);
      for (int unsigned i = 0; i < len; i++)
         push_sample(pick_value(), ($urandom_range(3) == 0), (i == len - 1));
   endtask

   initial begin
      int unsigned sent, len;
      logic [SIZE_W-1:0] cur_size;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, solved override, single-sample set, zero size
      write_size(11'd4);
      push_sample(13'd0, 1'b0, 1'b0);
      push_sample(13'h1FFF, 1'b0, 1'b0);
      push_sample(13'h1FFF, 1'b1, 1'b0);
      push_sample(13'h1555, 1'b0, 1'b1);
      push_sample(13'h0AAA, 1'b0, 1'b1);
      push_sample(13'd4096, 1'b1, 1'b1);
      write_size(11'd0);
      push_sample(13'h1FFF, 1'b0, 1'b0);
      push_sample(13'd0, 1'b0, 1'b1);
      write_size(11'd2047);
      push_sample(13'h1FFF, 1'b0, 1'b0);
      push_sample(13'd1, 1'b0, 1'b1);
      write_size(11'd1);
      for (int i = 0; i < 6; i++) push_sample(13'h1FFF, 1'b0, (i == 5));

      for (int ph = 0; ph < 4; ph++) begin
         drain();
         idle_pct  = ph_idle[ph];
         stall_pct = ph_stall[ph];
         cur_size  = ph_size[ph];
         write_size(cur_size);
         sent = 0;
         if (ph == 0) begin
            // overfill the store so samples get dropped
            run_set(1030);
         end
         while (sent < 30) begin
            if ($urandom_range(9) == 0) begin
               cur_size = ($urandom_range(1) == 0) ? SIZE_W'($urandom_range(1, 64))
                                                   : SIZE_W'($urandom_range(2047));
               write_size(cur_size);
            end
            if (cur_size != 0 && cur_size <= 64 && $urandom_range(1) == 0)
               len = cur_size;
            else if ($urandom_range(7) == 0)
               len = $urandom_range(17, 120);
            else
               len = $urandom_range(1, 16);
            run_set(len);
            sent += len;
         end
      end

      drain();
      repeat (500) @(posedge clock);
      $display("covered %0d samples in %0d checked sets, %0d with dropped samples",
               samples_seen, sets_checked, overflow_sets);
      $display("sizes 0, 1, 1024 and 2047 plus random, under four idle/stall mixes");
      if (fail_count == 0) begin
         $display("sample_stats_confidence_core: match");
      end else begin
         $display("sample_stats_confidence_core: mismatch");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+design
design/scc_pkg.sv
design/scc_interfaces.sv
design/scc_div.sv
design/scc_sqrt.sv
design/scc_ctrl.sv
design/scc_datapath.sv
design/sample_stats_confidence_core.sv
design/scc_checker.sv
dv/scc_stats_checker.sv
dv/tb_sample_stats_confidence_core.sv
